FILE: rtl/bsm_pkg.sv
// Shared types, constants and the voltage step table of the battery capacity smoother.
// No dependencies; every other file imports this package.
package bsm_pkg;

  localparam int CAP_W     = 7;
  localparam int MV_W      = 13;
  localparam int STATUS_W  = 3;
  localparam int IVL_W     = 8;
  localparam int THR_W     = 7;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 8;

  localparam logic [CAP_W-1:0] CAP_FULL        = 7'd100;
  localparam logic [IVL_W-1:0] IVL_SLOW        = 8'd30;
  localparam logic [IVL_W-1:0] IVL_DEFAULT     = 8'd10;
  localparam logic [IVL_W-1:0] NORMAL_IVL_RST  = 8'd10;
  localparam logic [THR_W-1:0] FORCE_FULL_RST  = 7'd95;
  localparam logic [THR_W-1:0] RESAMPLE_RST    = 7'd90;

  typedef enum logic [STATUS_W-1:0] {
    ST_UNKNOWN      = 3'd0,
    ST_CHARGING     = 3'd1,
    ST_DISCHARGING  = 3'd2,
    ST_NOT_CHARGING = 3'd3,
    ST_FULL         = 3'd4
  } chg_status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NORMAL_INTERVAL = 2'd0,
    CFG_FORCE_FULL      = 2'd1,
    CFG_RESAMPLE        = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic             changed;
    logic [CAP_W-1:0] reported_capacity;
    logic [IVL_W-1:0] next_interval_s;
  } result_t;

  localparam int VOLT_STEPS = 10;

  localparam logic [MV_W-1:0] VOLT_EDGE [VOLT_STEPS] = '{
    13'd3500, 13'd3550, 13'd3600, 13'd3700, 13'd3800,
    13'd3850, 13'd3900, 13'd3950, 13'd4000, 13'd4250
  };

  localparam logic [CAP_W-1:0] VOLT_CAP [VOLT_STEPS+1] = '{
    7'd2, 7'd10, 7'd20, 7'd30, 7'd40, 7'd50,
    7'd60, 7'd65, 7'd70, 7'd85, 7'd100
  };

  // Edges rise monotonically, so the last edge passed picks the step.
  function automatic logic [CAP_W-1:0] cap_from_mv(input logic [MV_W-1:0] mv);
    logic [CAP_W-1:0] cap;
    cap = VOLT_CAP[0];
    for (int k = 0; k < VOLT_STEPS; k++) begin
      if (mv >= VOLT_EDGE[k]) begin
        cap = VOLT_CAP[k+1];
      end
    end
    return cap;
  endfunction

endpackage

FILE: rtl/bsm_slot_cell.sv
// One slot of the averaging window: preload on the first sample, else take the
// neighbor's value on each shift. Depends on bsm_pkg.
module bsm_slot_cell
  import bsm_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             shift_i,
  input  logic             load_i,
  input  logic [CAP_W-1:0] load_val_i,
  input  logic [CAP_W-1:0] prev_i,
  output logic [CAP_W-1:0] slot_o
);

  logic [CAP_W-1:0] slot_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= '0;
    end else if (load_i) begin
      slot_q <= load_val_i;
    end else if (shift_i) begin
      slot_q <= prev_i;
    end
  end

  assign slot_o = slot_q;

endmodule

FILE: rtl/bsm_skid.sv
// Output register with a skid stage so a new word is taken while a result waits.
// Depends on bsm_pkg (result_t).
module bsm_skid
  import bsm_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  result_t in_data_i,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output result_t out_data_o
);

  logic    out_valid_q, skid_valid_q;
  result_t out_q, skid_q;
  logic    push, pop;

  assign in_ready_o = !skid_valid_q;
  assign push       = in_valid_i && !skid_valid_q;
  assign pop        = out_valid_q && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || pop) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= push;
      end
    end else if (push) begin
      skid_valid_q <= 1'b1;
    end
  end

  // payload: advance from skid first, else from the input
  always_ff @(posedge clk_i) begin
    if (!out_valid_q || pop) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (push) begin
        out_q <= in_data_i;
      end
    end else if (push) begin
      skid_q <= in_data_i;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

FILE: rtl/battery_capacity_smoother.sv
// Top level of the battery capacity smoother: sample decode, forced-full counter,
// window of slot cells with running sum, averaging, output skid. Uses bsm_pkg,
// bsm_slot_cell and bsm_skid.
//
//   channel   direction  handshake                       payload
//   s_axis    in         s_axis_tvalid / s_axis_tready   one sample word
//   m_axis    out        m_axis_tvalid / m_axis_tready   one result word per sample
//   cfg       in         cfg_we_i (no wait)              cfg_idx_i, cfg_data_i
//
// Timing: one sample word a cycle while s_axis_tready is high. All decode, window
// update and averaging happen in the accept cycle; the result is registered.
// Reset: all control state clears, thresholds take their defaults, the window reads
// zero until the first sample preloads it.
// Stalls: a skid stage holds one extra result, so s_axis_tready drops only when both
// the output register and the skid stage are full.
module battery_capacity_smoother
  import bsm_pkg::*;
#(
  parameter int WINDOW     = 10,
  parameter int FULL_TICKS = 80
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // gauge_capacity[6:0], battery_mv[19:7], battery_present[20], factory_mode[21],
  // chg_status[24:22], power_down[25], zero fill[31:26]
  input  logic [31:0]          s_axis_tdata,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // changed[0], reported_capacity[7:1], next_interval_s[15:8]
  output logic [15:0]          m_axis_tdata,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i
);

  // Widths of the running sum, the full counter and the averaging datapath.
  localparam int SUM_W     = $clog2(100 * WINDOW + 1);
  localparam int CNT_W     = $clog2(FULL_TICKS + 1);
  localparam int NUM_W     = $clog2(200 * WINDOW + WINDOW + 1);
  // avg = floor((2*sum + WINDOW) / (2*WINDOW)) is round-half-up of sum/WINDOW.
  // Reciprocal multiply is exact for every numerator below 2^12.
  localparam int AVG_SHIFT = 18;
  localparam int AVG_DIV   = 2 * WINDOW;
  localparam int AVG_MUL   = ((1 << AVG_SHIFT) + AVG_DIV - 1) / AVG_DIV;
  localparam int MUL_W     = 18;
  localparam int PROD_W    = NUM_W + MUL_W;

  // ---------------------------------------------------------------- config
  logic [IVL_W-1:0] normal_ivl_q;
  logic [THR_W-1:0] force_full_q, resample_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      normal_ivl_q <= NORMAL_IVL_RST;
      force_full_q <= FORCE_FULL_RST;
      resample_q   <= RESAMPLE_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_NORMAL_INTERVAL: normal_ivl_q <= cfg_data_i;
        CFG_FORCE_FULL:      force_full_q <= cfg_data_i[THR_W-1:0];
        CFG_RESAMPLE:        resample_q   <= cfg_data_i[THR_W-1:0];
        default: ;  // index beyond the register list: drop
      endcase
    end
  end

  // ---------------------------------------------------------------- sample decode
  logic [CAP_W-1:0]    gauge;
  logic [MV_W-1:0]     mv;
  logic                present, factory, pdown;
  logic [STATUS_W-1:0] status;
  logic                accept;

  assign gauge   = s_axis_tdata[6:0];
  assign mv      = s_axis_tdata[19:7];
  assign present = s_axis_tdata[20];
  assign factory = s_axis_tdata[21];
  assign status  = s_axis_tdata[24:22];
  assign pdown   = s_axis_tdata[25];
  assign accept  = s_axis_tvalid && s_axis_tready;

  logic charging, draining;
  assign charging = (status == ST_CHARGING) || (status == ST_FULL);
  assign draining = (status == ST_DISCHARGING) || (status == ST_NOT_CHARGING);

  // Raw capacity: voltage table without a battery or in factory mode, else the
  // gauge saturated at full.
  logic [CAP_W-1:0] cur_raw;
  always_comb begin
    if (!present || factory) begin
      cur_raw = cap_from_mv(mv);
    end else if (gauge > CAP_FULL) begin
      cur_raw = CAP_FULL;
    end else begin
      cur_raw = gauge;
    end
  end

  // ---------------------------------------------------------------- state
  logic             started_q, started_d;
  logic             shutdown_q, shutdown_d;
  logic [CAP_W-1:0] held_q, held_d;
  logic [SUM_W-1:0] sum_q, sum_d;
  logic [CNT_W-1:0] full_cnt_q, full_cnt_d;
  logic [IVL_W-1:0] hint_q, hint_d;

  // Forced full: count charging samples above the threshold, saturate at the limit.
  logic             over_thr, force_full;
  logic [CNT_W-1:0] cnt_inc, cnt_next;
  logic [CAP_W-1:0] cur;

  assign over_thr   = (cur_raw > force_full_q) && charging;
  assign cnt_inc    = (full_cnt_q >= CNT_W'(FULL_TICKS)) ? CNT_W'(FULL_TICKS)
                                                         : full_cnt_q + 1'b1;
  assign force_full = over_thr && (cnt_inc == CNT_W'(FULL_TICKS));
  assign cnt_next   = over_thr ? cnt_inc : '0;
  assign cur        = force_full ? CAP_FULL : cur_raw;

  logic [IVL_W-1:0] normal_hint, hint_new;
  assign normal_hint = (normal_ivl_q == '0) ? IVL_DEFAULT : normal_ivl_q;
  assign hint_new    = (cur > resample_q) ? IVL_SLOW : normal_hint;

  // ---------------------------------------------------------------- window cells
  // The row of cells is a shift line: cell 0 takes the new sample and the last
  // cell holds the oldest one, which is the slot a ring pointer would replace.
  logic             win_shift, win_load;
  logic [CAP_W-1:0] slot_w [WINDOW];

  for (genvar i = 0; i < WINDOW; i++) begin : g_cell
    logic [CAP_W-1:0] prev;
    if (i == 0) begin : g_head
      assign prev = cur;
    end else begin : g_link
      assign prev = slot_w[i-1];
    end
    bsm_slot_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .shift_i    (win_shift),
      .load_i     (win_load),
      .load_val_i (cur_raw),
      .prev_i     (prev),
      .slot_o     (slot_w[i])
    );
  end

  // Running sum: drop the oldest slot, add the new sample.
  logic [SUM_W-1:0]  sum_upd;
  logic [NUM_W-1:0]  avg_num;
  logic [PROD_W-1:0] avg_prod;
  logic [CAP_W-1:0]  avg;
  logic              refuse;

  assign sum_upd  = sum_q - SUM_W'(slot_w[WINDOW-1]) + SUM_W'(cur);
  assign avg_num  = (NUM_W'(sum_upd) << 1) + NUM_W'(WINDOW);
  assign avg_prod = PROD_W'(avg_num) * PROD_W'(MUL_W'(AVG_MUL));
  assign avg      = avg_prod[AVG_SHIFT +: CAP_W];
  // Hold the last announced value on no change or on a rise while draining.
  assign refuse   = ((held_q < avg) && draining) || (held_q == avg);

  // ---------------------------------------------------------------- next state and result
  result_t res;

  always_comb begin
    started_d  = started_q;
    shutdown_d = shutdown_q;
    held_d     = held_q;
    sum_d      = sum_q;
    full_cnt_d = full_cnt_q;
    hint_d     = hint_q;
    win_shift  = 1'b0;
    win_load   = 1'b0;
    res        = '{changed: 1'b1, reported_capacity: '0, next_interval_s: hint_q};
    if (shutdown_q || pdown) begin
      // latched power-down: report zero and freeze everything else
      shutdown_d = 1'b1;
    end else if (!started_q) begin
      // first sample: preload every slot and announce it as is
      started_d             = 1'b1;
      held_d                = cur_raw;
      sum_d                 = SUM_W'(cur_raw) * SUM_W'(WINDOW);
      win_load              = accept;
      res.reported_capacity = cur_raw;
    end else begin
      full_cnt_d            = cnt_next;
      hint_d                = hint_new;
      sum_d                 = sum_upd;
      win_shift             = accept;
      res.next_interval_s   = hint_new;
      res.changed           = !refuse;
      res.reported_capacity = refuse ? held_q : avg;
      held_d                = refuse ? held_q : avg;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q  <= 1'b0;
      shutdown_q <= 1'b0;
      held_q     <= '0;
      sum_q      <= '0;
      full_cnt_q <= '0;
      hint_q     <= NORMAL_IVL_RST;
    end else if (accept) begin
      started_q  <= started_d;
      shutdown_q <= shutdown_d;
      held_q     <= held_d;
      sum_q      <= sum_d;
      full_cnt_q <= full_cnt_d;
      hint_q     <= hint_d;
    end
  end

  // ---------------------------------------------------------------- output
  result_t out_res;

  bsm_skid u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_data_i   (res),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (out_res)
  );

  assign m_axis_tdata = {out_res.next_interval_s, out_res.reported_capacity, out_res.changed};

  // ---------------------------------------------------------------- assertions
  a_shutdown_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    shutdown_q |=> shutdown_q)
    else $error("power-down latch released");

  a_full_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_cnt_q <= CNT_W'(FULL_TICKS))
    else $error("forced-full counter past its limit");

  a_cnt_idle_before_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !started_q |-> (full_cnt_q == '0))
    else $error("forced-full counter moved before the first sample");

  a_frozen_after_shutdown: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && shutdown_q) |=> ($stable(sum_q) && $stable(held_q) && $stable(hint_q)))
    else $error("state changed while power-down is latched");

endmodule

FILE: tb/bsm_capacity_checker.sv
// Checker for the battery capacity smoother: watches the sample, result and register
// channels, predicts each result word and compares it field by field.
// Depends on bsm_pkg for widths, status codes, register indexes and interval constants.
module bsm_capacity_checker
  import bsm_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  input  logic                 s_axis_tready,
  input  logic [31:0]          s_axis_tdata,
  input  logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  input  logic [15:0]          m_axis_tdata,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  output int                   errors_o,
  output int                   pending_o
);

  localparam int WIN        = 10;
  localparam int FULL_COUNT = 80;

  // register copies
  logic [IVL_W-1:0] normal_ivl;
  logic [THR_W-1:0] full_thr;
  logic [THR_W-1:0] resample_thr;

  // smoother state
  logic             started_q;
  logic [CAP_W-1:0] held_q;
  int               slots_q [WIN];
  int               sum_q;
  int               ptr_q;
  int               full_cnt_q;
  logic             down_q;
  logic [IVL_W-1:0] hint_q;

  result_t          reports_q [$];
  int               fails;

  function automatic int volt_step_cap(input logic [MV_W-1:0] mv);
    int edges [10];
    int caps  [11];
    int k;
    edges = '{3500, 3550, 3600, 3700, 3800, 3850, 3900, 3950, 4000, 4250};
    caps  = '{2, 10, 20, 30, 40, 50, 60, 65, 70, 85, 100};
    k = 0;
    while (k < 10 && int'(mv) >= edges[k]) k++;
    return caps[k];
  endfunction

  task automatic predict_report(input logic [31:0] w, output result_t r);
    logic [CAP_W-1:0]    gauge;
    logic [MV_W-1:0]     mv;
    logic                present;
    logic                factory;
    logic [STATUS_W-1:0] status;
    logic                pdown;
    logic                charging;
    logic                draining;
    int                  cur;
    int                  avg;
    gauge    = w[6:0];
    mv       = w[19:7];
    present  = w[20];
    factory  = w[21];
    status   = w[24:22];
    pdown    = w[25];
    charging = (status == ST_CHARGING) || (status == ST_FULL);
    draining = (status == ST_DISCHARGING) || (status == ST_NOT_CHARGING);

    if (pdown) down_q = 1'b1;
    if (down_q) begin
      // frozen: announce zero, keep the last hint
      r.changed           = 1'b1;
      r.reported_capacity = '0;
      r.next_interval_s   = hint_q;
    end else begin
      if (!present || factory) cur = volt_step_cap(mv);
      else cur = (gauge > 100) ? 100 : int'(gauge);

      if (!started_q) begin
        // preload the whole window with the first value
        started_q = 1'b1;
        held_q    = cur[CAP_W-1:0];
        foreach (slots_q[k]) slots_q[k] = cur;
        sum_q     = cur * WIN;
        ptr_q     = 0;
        r.changed           = 1'b1;
        r.reported_capacity = cur[CAP_W-1:0];
        r.next_interval_s   = hint_q;
      end else begin
        if (cur > int'(full_thr) && charging) begin
          full_cnt_q++;
          if (full_cnt_q >= FULL_COUNT) begin
            full_cnt_q = FULL_COUNT;
            cur        = 100;
          end
        end else begin
          full_cnt_q = 0;
        end

        if (cur > int'(resample_thr)) hint_q = IVL_SLOW;
        else hint_q = (normal_ivl == '0) ? IVL_DEFAULT : normal_ivl;

        if (ptr_q >= WIN) ptr_q = 0;
        sum_q          = sum_q - slots_q[ptr_q] + cur;
        slots_q[ptr_q] = cur;
        ptr_q++;
        if (ptr_q >= WIN) ptr_q = 0;

        // round half up
        avg = ((sum_q * 10) / WIN + 5) / 10;

        r.next_interval_s = hint_q;
        if ((int'(held_q) < avg && draining) || int'(held_q) == avg) begin
          r.changed           = 1'b0;
          r.reported_capacity = held_q;
        end else begin
          held_q              = avg[CAP_W-1:0];
          r.changed           = 1'b1;
          r.reported_capacity = held_q;
        end
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    result_t got;
    if (!rst_ni) begin
      normal_ivl   = NORMAL_IVL_RST;
      full_thr     = FORCE_FULL_RST;
      resample_thr = RESAMPLE_RST;
      started_q    = 1'b0;
      held_q       = '0;
      foreach (slots_q[k]) slots_q[k] = 0;
      sum_q        = 0;
      ptr_q        = 0;
      full_cnt_q   = 0;
      down_q       = 1'b0;
      hint_q       = NORMAL_IVL_RST;
      reports_q.delete();
      fails        = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_NORMAL_INTERVAL: normal_ivl = cfg_data_i;
          CFG_FORCE_FULL:      full_thr = cfg_data_i[THR_W-1:0];
          CFG_RESAMPLE:        resample_thr = cfg_data_i[THR_W-1:0];
          default: ;
        endcase
      end

      // check before predicting: a result never belongs to a sample of the same edge
      if (m_axis_tvalid && m_axis_tready) begin
        got.changed           = m_axis_tdata[0];
        got.reported_capacity = m_axis_tdata[7:1];
        got.next_interval_s   = m_axis_tdata[15:8];
        if (reports_q.size() == 0) begin
          $error("result word 0x%04h with no sample waiting", m_axis_tdata);
          fails++;
        end else begin
          want = reports_q.pop_front();
          if (got.changed !== want.changed) begin
            $error("changed: expected %0d actual %0d", want.changed, got.changed);
            fails++;
          end
          if (got.reported_capacity !== want.reported_capacity) begin
            $error("reported_capacity: expected %0d actual %0d",
                   want.reported_capacity, got.reported_capacity);
            fails++;
          end
          if (got.next_interval_s !== want.next_interval_s) begin
            $error("next_interval_s: expected %0d actual %0d",
                   want.next_interval_s, got.next_interval_s);
            fails++;
          end
        end
      end

      if (s_axis_tvalid && s_axis_tready) begin
        predict_report(s_axis_tdata, want);
        reports_q.push_back(want);
      end
    end
    pending_o = reports_q.size();
    errors_o  = fails;
  end

endmodule

FILE: tb/tb_battery_capacity_smoother.sv
// Top of the battery capacity smoother testbench: clock, reset, sample stimulus,
// result-side back-pressure, register writes and the verdict.
// Depends on bsm_pkg, battery_capacity_smoother and bsm_capacity_checker.
module tb_battery_capacity_smoother;
  import bsm_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASE_WORDS = 145;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [31:0]          s_axis_tdata = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [15:0]          m_axis_tdata;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_W-1:0]     cfg_data_i = '0;

  int                   errors;
  int                   pending;
  int                   cycles = 0;
  int                   rx_words = 0;
  int                   hold_left = 0;
  bit                   long_hold_done = 1'b0;
  // 0: sender idles rarely, receiver mostly; 1: the reverse; 2: no idling
  int                   idle_mode = 2;
  // current force-full threshold, used to aim charging runs above it
  int                   full_thr = 95;
  int                   drift_cap = 50;

  always #5 clk_i = ~clk_i;

  battery_capacity_smoother dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  bsm_capacity_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .errors_o      (errors),
    .pending_o     (pending)
  );

  // Hard stop: a hung handshake must not run forever.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAIL battery_capacity_smoother");
      $finish;
    end
  end

  // Count result words taken, so the receiver knows when to start its long hold.
  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) rx_words++;
  end

  // Receiver: one long hold once 150 words have been taken (lets the block fill up
  // and drop s_axis_tready), otherwise random back-pressure by idle mode.
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (!long_hold_done && rx_words >= 150) begin
      long_hold_done = 1'b1;
      hold_left = 59;
      m_axis_tready <= 1'b0;
    end else begin
      case (idle_mode)
        0:       m_axis_tready <= ($urandom_range(99) >= 81);
        1:       m_axis_tready <= ($urandom_range(99) >= 9);
        default: m_axis_tready <= 1'b1;
      endcase
    end
  end

  // Pack one sample word, lowest field first.
  function automatic logic [31:0] pack_sample(input logic [6:0] gauge,
                                              input logic [12:0] mv,
                                              input logic present, input logic factory,
                                              input logic [2:0] status, input logic pdown);
    return {6'b0, pdown, status, factory, present, mv, gauge};
  endfunction

  // Offer one word, idling first at the sender's rate; return once it is taken.
  // tvalid stays high afterward so back-to-back words need no extra edge.
  task automatic push_sample(input logic [31:0] w);
    @(negedge clk_i);
    while ((idle_mode == 0 && $urandom_range(99) < 9) ||
           (idle_mode == 1 && $urandom_range(99) < 81)) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= w;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Drop tvalid and hold until every predicted word has come out.
  task automatic drain_results();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  // Charging run above the force-full threshold; long runs reach forced full.
  // A rare discharging word breaks the count.
  task automatic charge_run(input int n);
    int lo;
    for (int i = 0; i < n; i++) begin
      lo = (full_thr < 100) ? full_thr + 1 : 100;
      if ($urandom_range(39) == 0) begin
        push_sample(pack_sample(7'($urandom_range(127)), 13'($urandom_range(8191)), 1'b1,
                                1'b0, ST_DISCHARGING, 1'b0));
      end else if ($urandom_range(15) == 0) begin
        // voltage path at the top step also gives 100
        push_sample(pack_sample(7'($urandom_range(127)), 13'($urandom_range(8191, 4250)),
                                1'b0, 1'($urandom_range(1)), ST_FULL, 1'b0));
      end else begin
        push_sample(pack_sample(7'($urandom_range(127, lo)), 13'($urandom_range(8191)),
                                1'b1, 1'b0, $urandom_range(1) ? ST_CHARGING : ST_FULL,
                                1'b0));
      end
    end
  endtask

  // Gauge that wanders a few percent per word with any status.
  task automatic drift_run(input int n);
    for (int i = 0; i < n; i++) begin
      drift_cap = drift_cap + $urandom_range(6) - 3;
      if (drift_cap < 0) drift_cap = 0;
      if (drift_cap > 100) drift_cap = 100;
      push_sample(pack_sample(7'(drift_cap), 13'($urandom_range(8191)), 1'b1, 1'b0,
                              3'($urandom_range(7)), 1'b0));
    end
  endtask

  // Voltage table path: no battery or factory mode.
  task automatic volt_run(input int n);
    logic pres;
    for (int i = 0; i < n; i++) begin
      pres = 1'($urandom_range(1));
      push_sample(pack_sample(7'($urandom_range(127)), 13'($urandom_range(4400, 3400)),
                              pres, pres ? 1'b1 : 1'b0, 3'($urandom_range(7)), 1'b0));
    end
  endtask

  task automatic noise_run(input int n);
    for (int i = 0; i < n; i++) begin
      push_sample(pack_sample(7'($urandom_range(127)), 13'($urandom_range(8191)),
                              1'($urandom_range(1)), 1'($urandom_range(1)),
                              3'($urandom_range(7)), 1'b0));
    end
  endtask

  // One phase: open with a forced-full run, then a mix of run kinds.
  task automatic run_phase(input int words);
    int left;
    int n;
    int kind;
    left = words - 85;
    charge_run(85);
    while (left > 0) begin
      kind = $urandom_range(9);
      case (kind)
        0, 1:    n = $urandom_range(40, 10);
        2, 3, 4: n = $urandom_range(20, 5);
        5, 6:    n = $urandom_range(10, 3);
        default: n = $urandom_range(8, 1);
      endcase
      if (n > left) n = left;
      case (kind)
        0, 1:    charge_run(n);
        2, 3, 4: drift_run(n);
        5, 6:    volt_run(n);
        default: noise_run(n);
      endcase
      left -= n;
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part at the reset register values, no idling.
    // First sample: voltage table, preloads the window.
    push_sample(pack_sample(7'd0, 13'd3000, 1'b0, 1'b0, ST_DISCHARGING, 1'b0));
    // Walk the table edges, some on both sides, through both table selects and every status but discharging.
    push_sample(pack_sample(7'd50, 13'd3499, 1'b0, 1'b0, ST_CHARGING, 1'b0));
    push_sample(pack_sample(7'd50, 13'd3500, 1'b1, 1'b1, ST_UNKNOWN, 1'b0));
    push_sample(pack_sample(7'd50, 13'd3550, 1'b0, 1'b1, ST_NOT_CHARGING, 1'b0));
    push_sample(pack_sample(7'd50, 13'd3600, 1'b0, 1'b0, ST_FULL, 1'b0));
    push_sample(pack_sample(7'd50, 13'd3700, 1'b1, 1'b1, 3'd5, 1'b0));
    push_sample(pack_sample(7'd50, 13'd3800, 1'b0, 1'b0, 3'd6, 1'b0));
    push_sample(pack_sample(7'd50, 13'd3850, 1'b0, 1'b1, 3'd7, 1'b0));
    push_sample(pack_sample(7'd50, 13'd3900, 1'b0, 1'b0, ST_UNKNOWN, 1'b0));
    push_sample(pack_sample(7'd50, 13'd3950, 1'b1, 1'b1, ST_CHARGING, 1'b0));
    push_sample(pack_sample(7'd50, 13'd3999, 1'b0, 1'b0, ST_CHARGING, 1'b0));
    push_sample(pack_sample(7'd50, 13'd4000, 1'b0, 1'b0, ST_CHARGING, 1'b0));
    push_sample(pack_sample(7'd50, 13'd4249, 1'b0, 1'b1, ST_CHARGING, 1'b0));
    push_sample(pack_sample(7'd50, 13'd4250, 1'b0, 1'b0, ST_CHARGING, 1'b0));
    push_sample(pack_sample(7'd50, 13'd8191, 1'b1, 1'b1, ST_FULL, 1'b0));
    // Gauge path: saturation above 100, extremes, refused rise while draining.
    push_sample(pack_sample(7'd127, 13'd0, 1'b1, 1'b0, ST_CHARGING, 1'b0));
    push_sample(pack_sample(7'd100, 13'd0, 1'b1, 1'b0, ST_FULL, 1'b0));
    push_sample(pack_sample(7'd0, 13'd8191, 1'b1, 1'b0, ST_DISCHARGING, 1'b0));
    push_sample(pack_sample(7'd100, 13'd4000, 1'b1, 1'b0, ST_DISCHARGING, 1'b0));
    push_sample(pack_sample(7'd100, 13'd4000, 1'b1, 1'b0, ST_NOT_CHARGING, 1'b0));
    push_sample(pack_sample(7'd1, 13'd1234, 1'b1, 1'b0, ST_NOT_CHARGING, 1'b0));
    push_sample(pack_sample(7'd99, 13'd5000, 1'b1, 1'b0, 3'd5, 1'b0));
    // Sender pauses until every result is out.
    drain_results();

    // Phase A: zero interval (falls back to default), default force-full threshold, resample threshold at 100.
    write_reg(CFG_NORMAL_INTERVAL, 8'd0);
    write_reg(CFG_FORCE_FULL, 8'd95);
    write_reg(CFG_RESAMPLE, 8'd100);
    full_thr = 95;
    idle_mode = 0;
    run_phase(PHASE_WORDS);
    drain_results();

    // Phase B: widest interval, zero thresholds.
    write_reg(CFG_NORMAL_INTERVAL, 8'd255);
    write_reg(CFG_FORCE_FULL, 8'd0);
    write_reg(CFG_RESAMPLE, 8'd0);
    full_thr = 0;
    idle_mode = 1;
    run_phase(PHASE_WORDS);
    drain_results();

    // Phase C: random interval, a force-full threshold past 100 never trips, resample past 100 or random.
    write_reg(CFG_NORMAL_INTERVAL, 8'($urandom_range(254, 1)));
    write_reg(CFG_FORCE_FULL, 8'd127);
    write_reg(CFG_RESAMPLE, $urandom_range(1) ? 8'd127 : 8'($urandom_range(100)));
    full_thr = 127;
    idle_mode = 2;
    run_phase(PHASE_WORDS);

    // Latch power-down last: everything after it reports zero and the state freezes.
    push_sample(pack_sample(7'($urandom_range(127)), 13'($urandom_range(8191)), 1'b1, 1'b0,
                            3'($urandom_range(7)), 1'b1));
    for (int i = 0; i < 5; i++) begin
      push_sample(pack_sample(7'($urandom_range(127)), 13'($urandom_range(8191)),
                              1'($urandom_range(1)), 1'($urandom_range(1)),
                              3'($urandom_range(7)), 1'($urandom_range(1))));
    end

    // Let the last words drain, then give the verdict.
    drain_results();
    repeat (5) @(posedge clk_i);
    if (errors == 0) begin
      $display("PASS battery_capacity_smoother");
    end else begin
      $display("FAIL battery_capacity_smoother");
    end
    $finish;
  end

endmodule
